### rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and codes of the bilinear RGBA8 sampler: default sizes,
// request field offsets, register indexes and request kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brs_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CFG_W     = 9;
   localparam int CFG_IDX_W = 2;

   localparam int COORD_W    = 18;
   localparam int COORD_FRAC = 16;
   localparam int CLAMP_W    = COORD_FRAC + 1;
   localparam logic [CLAMP_W-1:0] COORD_ONE = {1'b1, {COORD_FRAC{1'b0}}};

   localparam int REQ_WX_LSB  = 0;
   localparam int REQ_WY_LSB  = 8;
   localparam int REQ_PIX_LSB = 16;
   localparam int REQ_U_LSB   = 48;
   localparam int REQ_V_LSB   = 66;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 32;

   localparam logic [RSP_TDATA_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_IMAGE_LOADED = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

endpackage

### rtl/bilinear_rgba_sampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_rgba_sampler_core
// Five register stages, the last being the response register; writes give no response.
// Throughput: one request per cycle when not back-pressured, set by four parity-split banks.
// Reset clears the pipeline and sets width 1, height 1 and no image loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_rgba_sampler_core #(
   parameter int MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = brs_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // write_x, write_y, pixel_argb, coord_u, coord_v, zero padding
   input  logic [brs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red, green, blue, alpha
   output logic [brs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [brs_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [brs_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int XBW        = (XW > 1) ? XW - 1 : 1;
   localparam int YBW        = (YW > 1) ? YW - 1 : 1;
   localparam int BAW        = XBW + YBW;
   localparam int BANK_DEPTH = 1 << BAW;
   localparam int CLAMP_W    = brs_pkg::CLAMP_W;
   localparam int CF         = brs_pkg::COORD_FRAC;
   localparam int PUW        = CF + XW;
   localparam int PVW        = CF + YW;
   localparam logic [FRAC_BITS:0] WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [FRAC_BITS-1:0] t);
      logic [FRAC_BITS:0]   wa;
      logic [FRAC_BITS+8:0] s;
      wa = WEIGHT_ONE - {1'b0, t};
      s  = a * wa + b * t;
      return s[FRAC_BITS +: 8];
   endfunction

   // Configuration registers
   logic [brs_pkg::CFG_W-1:0] csr_width_ff, csr_height_ff;
   logic                      csr_loaded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= brs_pkg::CFG_W'(1);
         csr_height_ff <= brs_pkg::CFG_W'(1);
         csr_loaded_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            brs_pkg::CSR_IMAGE_WIDTH:  csr_width_ff  <= csr_wdata;
            brs_pkg::CSR_IMAGE_HEIGHT: csr_height_ff <= csr_wdata;
            brs_pkg::CSR_IMAGE_LOADED: csr_loaded_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [brs_pkg::CFG_W-1:0] width_size, height_size, width_m1_full, height_m1_full;
   logic [XW-1:0]             width_m1;
   logic [YW-1:0]             height_m1;

   always_comb begin
      priority if (csr_width_ff == '0) begin
         width_size = brs_pkg::CFG_W'(1);
      end else if (32'(csr_width_ff) > MAX_WIDTH) begin
         width_size = brs_pkg::CFG_W'(MAX_WIDTH);
      end else begin
         width_size = csr_width_ff;
      end
      priority if (csr_height_ff == '0) begin
         height_size = brs_pkg::CFG_W'(1);
      end else if (32'(csr_height_ff) > MAX_HEIGHT) begin
         height_size = brs_pkg::CFG_W'(MAX_HEIGHT);
      end else begin
         height_size = csr_height_ff;
      end
      width_m1_full  = width_size - brs_pkg::CFG_W'(1);
      height_m1_full = height_size - brs_pkg::CFG_W'(1);
      width_m1       = XW'(width_m1_full);
      height_m1      = YW'(height_m1_full);
   end

   // Stage handshake
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   logic p1_valid_in, p2_valid_in, p3_valid_in, p4_valid_in, p5_valid_in;
   logic p1_load, p2_load, p3_load, p4_load, p5_load;

   assign p5_load    = !p5_valid_ff || rsp_tready;
   assign p4_load    = !p4_valid_ff || p5_load;
   assign p3_load    = !p3_valid_ff || p4_load;
   assign p2_load    = !p2_valid_ff || p3_load;
   assign p1_load    = !p1_valid_ff || p2_load;
   assign req_tready = p1_load;

   // Stage 1: request capture and coordinate clamp
   logic                      p1_sample_ff, p1_loaded_ff;
   logic [CLAMP_W-1:0]        p1_cu_ff, p1_cv_ff, p1_cu_in, p1_cv_in;
   logic [7:0]                p1_wx_ff, p1_wy_ff;
   logic [31:0]               p1_pix_ff;
   logic [brs_pkg::COORD_W-1:0] coord_u, coord_v;

   assign coord_u = req_tdata[brs_pkg::REQ_U_LSB +: brs_pkg::COORD_W];
   assign coord_v = req_tdata[brs_pkg::REQ_V_LSB +: brs_pkg::COORD_W];

   always_comb begin
      priority if (coord_u[brs_pkg::COORD_W-1]) begin
         p1_cu_in = '0;
      end else if (coord_u[CLAMP_W-1:0] > brs_pkg::COORD_ONE) begin
         p1_cu_in = brs_pkg::COORD_ONE;
      end else begin
         p1_cu_in = coord_u[CLAMP_W-1:0];
      end
      priority if (coord_v[brs_pkg::COORD_W-1]) begin
         p1_cv_in = '0;
      end else if (coord_v[CLAMP_W-1:0] > brs_pkg::COORD_ONE) begin
         p1_cv_in = brs_pkg::COORD_ONE;
      end else begin
         p1_cv_in = coord_v[CLAMP_W-1:0];
      end
   end

   assign p1_valid_in = p1_load ? req_tvalid : p1_valid_ff;

   always_ff @(posedge clock) begin
      if (p1_load) begin
         p1_sample_ff <= (req_tuser == brs_pkg::REQ_SAMPLE);
         p1_loaded_ff <= csr_loaded_ff;
         p1_cu_ff     <= p1_cu_in;
         p1_cv_ff     <= p1_cv_in;
         p1_wx_ff     <= req_tdata[brs_pkg::REQ_WX_LSB +: 8];
         p1_wy_ff     <= req_tdata[brs_pkg::REQ_WY_LSB +: 8];
         p1_pix_ff    <= req_tdata[brs_pkg::REQ_PIX_LSB +: 32];
      end
   end

   // Stage 2: scale coordinates by size minus one
   logic                  p2_sample_ff, p2_loaded_ff;
   logic [PUW-1:0]        p2_pu_ff, p2_pu_in;
   logic [PVW-1:0]        p2_pv_ff, p2_pv_in;
   logic [7:0]            p2_wx_ff, p2_wy_ff;
   logic [31:0]           p2_pix_ff;
   logic [CLAMP_W+XW-1:0] prod_u;
   logic [CLAMP_W+YW-1:0] prod_v;

   assign prod_u      = p1_cu_ff * width_m1;
   assign prod_v      = p1_cv_ff * height_m1;
   assign p2_pu_in    = prod_u[PUW-1:0];
   assign p2_pv_in    = prod_v[PVW-1:0];
   assign p2_valid_in = p2_load ? p1_valid_ff : p2_valid_ff;

   always_ff @(posedge clock) begin
      if (p2_load) begin
         p2_sample_ff <= p1_sample_ff;
         p2_loaded_ff <= p1_loaded_ff;
         p2_pu_ff     <= p2_pu_in;
         p2_pv_ff     <= p2_pv_in;
         p2_wx_ff     <= p1_wx_ff;
         p2_wy_ff     <= p1_wy_ff;
         p2_pix_ff    <= p1_pix_ff;
      end
   end

   // Stage 3: neighbour addresses and the banked pixel store
   logic [XW-1:0]        x0, col_even_full, col_odd_full;
   logic [YW-1:0]        y0, row_even_full, row_odd_full;
   logic [XW:0]          x0_ext, x0_inc;
   logic [YW:0]          y0_ext, y0_inc;
   logic [XBW-1:0]       col_even, col_odd, wcol;
   logic [YBW-1:0]       row_even, row_odd, wrow;
   logic [CF-1:0]        fx, fy;
   logic [FRAC_BITS-1:0] p3_tx_in, p3_ty_in;
   logic                 bx1, by1, w_inrange;
   logic [1:0]           wbank;

   assign x0            = p2_pu_ff[CF +: XW];
   assign y0            = p2_pv_ff[CF +: YW];
   assign fx            = p2_pu_ff[CF-1:0];
   assign fy            = p2_pv_ff[CF-1:0];
   assign x0_ext        = {1'b0, x0};
   assign y0_ext        = {1'b0, y0};
   assign x0_inc        = x0_ext + 1'b1;
   assign y0_inc        = y0_ext + 1'b1;
   assign col_even_full = x0_inc[XW:1];
   assign col_odd_full  = x0_ext[XW:1];
   assign row_even_full = y0_inc[YW:1];
   assign row_odd_full  = y0_ext[YW:1];
   assign col_even      = col_even_full[XBW-1:0];
   assign col_odd       = col_odd_full[XBW-1:0];
   assign row_even      = row_even_full[YBW-1:0];
   assign row_odd       = row_odd_full[YBW-1:0];
   assign bx1           = (x0 == width_m1) ? x0[0] : !x0[0];
   assign by1           = (y0 == height_m1) ? y0[0] : !y0[0];

   generate
      if (FRAC_BITS >= CF) begin : g_weight_up
         assign p3_tx_in = FRAC_BITS'(fx) << (FRAC_BITS - CF);
         assign p3_ty_in = FRAC_BITS'(fy) << (FRAC_BITS - CF);
      end else begin : g_weight_down
         assign p3_tx_in = fx[CF-1 -: FRAC_BITS];
         assign p3_ty_in = fy[CF-1 -: FRAC_BITS];
      end
   endgenerate

   assign w_inrange = (32'(p2_wx_ff) < MAX_WIDTH) && (32'(p2_wy_ff) < MAX_HEIGHT);
   assign wbank     = {p2_wy_ff[0], p2_wx_ff[0]};
   assign wcol      = XBW'(p2_wx_ff >> 1);
   assign wrow      = YBW'(p2_wy_ff >> 1);

   logic [31:0] bank_rd_ff [4];

   generate
      for (genvar b = 0; b < 4; b++) begin : g_bank
         logic [31:0]    mem [BANK_DEPTH];
         logic [BAW-1:0] raddr, waddr;
         logic           we;

         assign raddr = {(b >= 2) ? row_odd : row_even, ((b % 2) != 0) ? col_odd : col_even};
         assign waddr = {wrow, wcol};
         assign we    = p3_load && p2_valid_ff && !p2_sample_ff && w_inrange
                        && (wbank == 2'(b));

         always_ff @(posedge clock) begin
            if (we) begin
               mem[waddr] <= p2_pix_ff;
            end
            if (p3_load) begin
               bank_rd_ff[b] <= mem[raddr];
            end
         end
      end
   endgenerate

   logic                 p3_loaded_ff;
   logic [FRAC_BITS-1:0] p3_tx_ff, p3_ty_ff;
   logic [1:0]           p3_sel00_ff, p3_sel10_ff, p3_sel01_ff, p3_sel11_ff;

   assign p3_valid_in = p3_load ? (p2_valid_ff && p2_sample_ff) : p3_valid_ff;

   always_ff @(posedge clock) begin
      if (p3_load) begin
         p3_loaded_ff <= p2_loaded_ff;
         p3_tx_ff     <= p3_tx_in;
         p3_ty_ff     <= p3_ty_in;
         p3_sel00_ff  <= {y0[0], x0[0]};
         p3_sel10_ff  <= {y0[0], bx1};
         p3_sel01_ff  <= {by1, x0[0]};
         p3_sel11_ff  <= {by1, bx1};
      end
   end

   // Stage 4: horizontal lerps
   logic [31:0]          p00, p10, p01, p11;
   logic [7:0]           p4_top_ff [4], p4_bot_ff [4], p4_top_in [4], p4_bot_in [4];
   logic                 p4_loaded_ff;
   logic [FRAC_BITS-1:0] p4_ty_ff;

   assign p00 = bank_rd_ff[p3_sel00_ff];
   assign p10 = bank_rd_ff[p3_sel10_ff];
   assign p01 = bank_rd_ff[p3_sel01_ff];
   assign p11 = bank_rd_ff[p3_sel11_ff];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p4_top_in[i] = lerp8(p00[8*i +: 8], p10[8*i +: 8], p3_tx_ff);
         p4_bot_in[i] = lerp8(p01[8*i +: 8], p11[8*i +: 8], p3_tx_ff);
      end
   end

   assign p4_valid_in = p4_load ? p3_valid_ff : p4_valid_ff;

   always_ff @(posedge clock) begin
      if (p4_load) begin
         p4_loaded_ff <= p3_loaded_ff;
         p4_ty_ff     <= p3_ty_ff;
         p4_top_ff    <= p4_top_in;
         p4_bot_ff    <= p4_bot_in;
      end
   end

   // Stage 5: vertical lerp into the response register
   logic [7:0]                      lane [4];
   logic [brs_pkg::RSP_TDATA_W-1:0] p5_data_ff, p5_data_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lane[i] = lerp8(p4_top_ff[i], p4_bot_ff[i], p4_ty_ff);
      end
      if (p4_loaded_ff) begin
         p5_data_in = {lane[3], lane[0], lane[1], lane[2]};
      end else begin
         p5_data_in = brs_pkg::OPAQUE_BLACK;
      end
   end

   assign p5_valid_in = p5_load ? p4_valid_ff : p5_valid_ff;

   always_ff @(posedge clock) begin
      if (p5_load) begin
         p5_data_ff <= p5_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         p3_valid_ff <= p3_valid_in;
         p4_valid_ff <= p4_valid_in;
         p5_valid_ff <= p5_valid_in;
      end
   end

   assign rsp_tvalid = p5_valid_ff;
   assign rsp_tdata  = p5_data_ff;

endmodule

### rtl/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the sampler: response hold under back-pressure,
// reset, input readiness and the fixed latency of a flowing pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [brs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic sample_acc, flow;

   assign sample_acc = req_tvalid && req_tready && (req_tuser == brs_pkg::REQ_SAMPLE);
   assign flow       = rsp_tready && !reset;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty response register");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(sample_acc, 5) && $past(flow, 1) && $past(flow, 2) && $past(flow, 3)
      && $past(flow, 4) |-> rsp_tvalid)
      else $error("sample response missing after five flowing cycles");

endmodule

bind bilinear_rgba_sampler_core brs_checker u_brs_checker (.*);

### dv/bilinear_rgba_sampler_core_test.sv
// ----------------------------------------------------------------------------
// bilinear_rgba_sampler_core_test
// Self-checking bench for the bilinear RGBA8 sampler. Pixel writes and sample
// requests are streamed in under several image sizes and flow-control
// patterns. A software image store predicts every interpolated pixel, and the
// responses are checked channel by channel in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_rgba_sampler_core_test;

   localparam int MAX_W = brs_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H = brs_pkg::MAX_HEIGHT_DEF;
   localparam int FRAC  = brs_pkg::FRAC_BITS_DEF;
   localparam int CW    = brs_pkg::COORD_W;
   localparam int CFRAC = brs_pkg::COORD_FRAC;
   localparam int STALL_LIMIT = 4000;
   localparam logic [brs_pkg::CFG_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CW-1:0] coord_v;
      logic [CW-1:0] coord_u;
      logic [31:0]   pixel_argb;
      logic [7:0]    write_y;
      logic [7:0]    write_x;
   } req_fields_type;

   typedef struct packed {
      brs_pkg::req_kind_type kind;
      req_fields_type        fields;
   } req_item_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [brs_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                              req_tuser  = brs_pkg::REQ_WRITE;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [brs_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [brs_pkg::CFG_IDX_W-1:0]     csr_index  = brs_pkg::CSR_IMAGE_WIDTH;
   logic [brs_pkg::CFG_W-1:0]         csr_wdata  = '0;

   req_item_type pending_requests[$];
   rgba_type     expected_rgba[$];
   req_item_type drv_item;
   logic         req_fire = 1'b0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  recv_stall_pct = 0;

   logic [31:0] image_store [0:MAX_W*MAX_H-1];
   bit          filled [0:MAX_W*MAX_H-1];
   logic [8:0]  cur_width  = 9'd1;
   logic [8:0]  cur_height = 9'd1;
   logic        cur_loaded = 1'b0;

   int error_count  = 0;
   int write_count  = 0;
   int sample_count = 0;
   int rsp_count    = 0;
   int phase_count  = 0;
   int quiet_cycles = 0;

   bilinear_rgba_sampler_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(logic [8:0] s, int unsigned maxv);
      if (s == 0) return 1;
      if (s > maxv) return maxv;
      return s;
   endfunction

   function automatic int unsigned clamp_coord(logic [CW-1:0] c);
      if (c[CW-1]) return 0;
      if (c > CW'(brs_pkg::COORD_ONE)) return int'(brs_pkg::COORD_ONE);
      return c;
   endfunction

   function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b,
                                        longint unsigned t);
      longint unsigned s;
      s = longint'(a) * ((64'd1 << FRAC) - t) + longint'(b) * t;
      return 8'(s >> FRAC);
   endfunction

   function automatic longint unsigned weight_of(int unsigned pos);
      longint unsigned f;
      f = pos & 32'hFFFF;
      if (FRAC >= CFRAC) return f << (FRAC - CFRAC);
      return f >> (CFRAC - FRAC);
   endfunction

   function automatic logic [7:0] mix_channel(logic [31:0] p00, logic [31:0] p10,
                                              logic [31:0] p01, logic [31:0] p11,
                                              int sh, longint unsigned tx,
                                              longint unsigned ty);
      logic [7:0] top;
      logic [7:0] bot;
      top = blend(p00[sh+:8], p10[sh+:8], tx);
      bot = blend(p01[sh+:8], p11[sh+:8], tx);
      return blend(top, bot, ty);
   endfunction

   function automatic rgba_type sample_rgba(logic [CW-1:0] u, logic [CW-1:0] v);
      int unsigned     w, h, pu, pv, x0, x1, y0, y1;
      longint unsigned tx, ty;
      logic [31:0]     p00, p10, p01, p11;
      rgba_type        r;
      if (!cur_loaded) begin
         r = brs_pkg::OPAQUE_BLACK;
         return r;
      end
      w  = clamp_dim(cur_width, MAX_W);
      h  = clamp_dim(cur_height, MAX_H);
      pu = clamp_coord(u) * (w - 1);
      pv = clamp_coord(v) * (h - 1);
      x0 = pu >> CFRAC;
      y0 = pv >> CFRAC;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      tx = weight_of(pu);
      ty = weight_of(pv);
      p00 = image_store[y0 * MAX_W + x0];
      p10 = image_store[y0 * MAX_W + x1];
      p01 = image_store[y1 * MAX_W + x0];
      p11 = image_store[y1 * MAX_W + x1];
      r.red   = mix_channel(p00, p10, p01, p11, 16, tx, ty);
      r.green = mix_channel(p00, p10, p01, p11, 8, tx, ty);
      r.blue  = mix_channel(p00, p10, p01, p11, 0, tx, ty);
      r.alpha = mix_channel(p00, p10, p01, p11, 24, tx, ty);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_channel(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got %0d expected %0d",
                                   rsp_count, name, got, want));
   endtask

   always @(negedge clock) begin : drive_req
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_requests.pop_front();
            drv_item   <= nxt;
            req_tdata  <= brs_pkg::REQ_TDATA_W'(nxt.fields);
            req_tuser  <= nxt.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : predict_req
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            if (drv_item.kind == brs_pkg::REQ_WRITE) begin
               image_store[drv_item.fields.write_y * MAX_W + drv_item.fields.write_x] =
                  drv_item.fields.pixel_argb;
               write_count++;
            end else begin
               expected_rgba.push_back(sample_rgba(drv_item.fields.coord_u,
                                                   drv_item.fields.coord_v));
               sample_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rgba_type got;
      rgba_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rgba.size() == 0) begin
            report_mismatch($sformatf("response %h with no sample outstanding", got));
         end else begin
            want = expected_rgba.pop_front();
            check_channel("red", got.red, want.red);
            check_channel("green", got.green, want.green);
            check_channel("blue", got.blue, want.blue);
            check_channel("alpha", got.alpha, want.alpha);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_rgba.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [brs_pkg::CFG_IDX_W-1:0] idx,
                            logic [brs_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         brs_pkg::CSR_IMAGE_WIDTH:  cur_width  = data;
         brs_pkg::CSR_IMAGE_HEIGHT: cur_height = data;
         brs_pkg::CSR_IMAGE_LOADED: cur_loaded = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_flow(flow_mode_type mode);
      case (mode)
         FLOW_FREE:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         FLOW_SENDER_IDLE:    begin send_idle_pct = 84; recv_stall_pct = 0;  end
         FLOW_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default:             begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
   endtask

   task automatic queue_write(logic [7:0] x, logic [7:0] y, logic [31:0] pix);
      req_item_type it;
      it = '0;
      it.kind = brs_pkg::REQ_WRITE;
      it.fields.write_x = x;
      it.fields.write_y = y;
      it.fields.pixel_argb = pix;
      pending_requests.push_back(it);
      filled[y * MAX_W + x] = 1'b1;
   endtask

   task automatic queue_sample(logic [CW-1:0] u, logic [CW-1:0] v);
      req_item_type it;
      it = '0;
      it.kind = brs_pkg::REQ_SAMPLE;
      it.fields.coord_u = u;
      it.fields.coord_v = v;
      pending_requests.push_back(it);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(9))
         0: return '0;
         1: return CW'(brs_pkg::COORD_ONE);
         2: return 18'h20000 | 18'($urandom());
         3: return 18'($urandom_range(65537, 131071));
         9: return 18'($urandom());
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic configure(logic [8:0] width_reg, logic [8:0] height_reg,
                            logic loaded_reg);
      wait_drained();
      write_csr(brs_pkg::CSR_IMAGE_WIDTH, width_reg);
      write_csr(brs_pkg::CSR_IMAGE_HEIGHT, height_reg);
      write_csr(brs_pkg::CSR_IMAGE_LOADED, brs_pkg::CFG_W'(loaded_reg));
      phase_count++;
   endtask

   task automatic run_phase(logic [8:0] width_reg, logic [8:0] height_reg,
                            logic loaded_reg, flow_mode_type mode, int n_items);
      int unsigned wc, hc;
      configure(width_reg, height_reg, loaded_reg);
      if ($urandom_range(1)) write_csr(CSR_SPARE, 9'($urandom()));
      set_flow(mode);
      wc = clamp_dim(width_reg, MAX_W);
      hc = clamp_dim(height_reg, MAX_H);
      // Every pixel a sample can reach is written before the first sample.
      if (loaded_reg)
         for (int y = 0; y < hc; y++)
            for (int x = 0; x < wc; x++)
               if (!filled[y * MAX_W + x]) queue_write(8'(x), 8'(y), $urandom());
      repeat (n_items) begin
         if ($urandom_range(99) < 20)
            queue_write(8'($urandom()), 8'($urandom()), $urandom());
         else
            queue_sample(rand_coord(), rand_coord());
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With no image loaded every sample is opaque black.
      set_flow(FLOW_FREE);
      queue_sample(18'h00000, 18'h00000);
      queue_sample(18'h1FFFF, 18'h1FFFF);
      queue_sample(18'h20000, 18'h20000);
      queue_write(8'd255, 8'd255, 32'h0000_0000);
      queue_write(8'd0, 8'd0, 32'hFFFF_FFFF);
      queue_write(8'd1, 8'd0, 32'h0000_0000);
      queue_write(8'd0, 8'd1, 32'h8040_2010);
      queue_write(8'd1, 8'd1, 32'h7FBF_DFEF);

      configure(9'd2, 9'd2, 1'b1);
      write_csr(CSR_SPARE, 9'h1FF);
      queue_sample(18'h00000, 18'h00000);
      queue_sample(18'h10000, 18'h10000);
      queue_sample(18'h08000, 18'h08000);
      queue_sample(18'h20000, 18'h1FFFF);
      queue_sample(18'h3FFFF, 18'h10001);
      queue_sample(18'h0FFFF, 18'h00001);
      queue_sample(18'h1FFFF, 18'h20000);
      queue_sample(18'h04000, 18'h0C000);

      run_phase(9'd1,   9'd1,   1'b1, FLOW_FREE,           20);
      run_phase(9'd0,   9'd3,   1'b1, FLOW_SENDER_IDLE,    20);
      run_phase(9'd256, 9'd1,   1'b1, FLOW_RECEIVER_STALL, 20);
      run_phase(9'd1,   9'd256, 1'b1, FLOW_BOTH,           20);
      run_phase(9'd511, 9'd1,   1'b1, FLOW_FREE,           20);
      run_phase(9'd5,   9'd7,   1'b0, FLOW_SENDER_IDLE,    20);
      run_phase(9'd8,   9'd8,   1'b1, FLOW_RECEIVER_STALL, 20);
      run_phase(9'd3,   9'd20,  1'b1, FLOW_BOTH,           20);
      for (int i = 0; i < 4; i++)
         run_phase(9'($urandom_range(2, 10)), 9'($urandom_range(2, 10)), 1'b1,
                   flow_mode_type'(i), 20);

      wait_drained();
      $display("Covered %0d pixel writes and %0d samples across %0d image settings.",
               write_count, sample_count, phase_count);
      $display("Checked %0d responses; %0d mismatches.", rsp_count, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
